### hdl/iouta_pkg.sv
// Shared types and codes for the IoU detection-to-track associator.
`default_nettype none
package iouta_pkg;

    typedef logic [2:0] status_t;

    localparam status_t ST_MATCHED = 3'd0;
    localparam status_t ST_NEW     = 3'd1;
    localparam status_t ST_SMALL   = 3'd2;
    localparam status_t ST_COUNT   = 3'd3;
    localparam status_t ST_FULL    = 3'd4;

    typedef logic [2:0] cfg_index_t;

    localparam cfg_index_t CFG_MIN_IOU    = 3'd0;
    localparam cfg_index_t CFG_MAX_RATIO  = 3'd1;
    localparam cfg_index_t CFG_MAX_AGE    = 3'd2;
    localparam cfg_index_t CFG_MIN_SIDE   = 3'd3;
    localparam cfg_index_t CFG_MAX_BOXES  = 3'd4;

    localparam int ID_BITS   = 31;
    localparam int TIME_BITS = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRUNE,
        S_CHECK,
        S_SCAN,
        S_DECIDE,
        S_OUTW
    } state_t;

    // Per-cell control strobes.
    typedef struct packed {
        logic shift;
        logic prune;
        logic write;
    } cell_ctl_t;

    // Outcome flags of one table scan.
    typedef struct packed {
        logic found;
        logic free_found;
    } scan_res_t;

endpackage
`default_nettype wire

### hdl/iouta_cell.sv
// One track slot of the rotating slot ring.
`default_nettype none
module iouta_cell
    import iouta_pkg::*;
#(
    parameter int CB = 13
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cell_ctl_t            ctl,
    input  wire logic [TIME_BITS-1:0] now,
    input  wire logic [13:0]          max_age,
    input  wire logic                 nb_valid,
    input  wire logic [CB-1:0]        nb_x,
    input  wire logic [CB-1:0]        nb_y,
    input  wire logic [CB-1:0]        nb_w,
    input  wire logic [CB-1:0]        nb_h,
    input  wire logic [TIME_BITS-1:0] nb_last,
    input  wire logic [ID_BITS-1:0]   nb_id,
    input  wire logic [CB-1:0]        wr_x,
    input  wire logic [CB-1:0]        wr_y,
    input  wire logic [CB-1:0]        wr_w,
    input  wire logic [CB-1:0]        wr_h,
    input  wire logic [ID_BITS-1:0]   wr_id,
    output logic                      valid,
    output logic [CB-1:0]             x,
    output logic [CB-1:0]             y,
    output logic [CB-1:0]             w,
    output logic [CB-1:0]             h,
    output logic [TIME_BITS-1:0]      last,
    output logic [ID_BITS-1:0]        id
);

    logic                 valid_reg;
    logic [CB-1:0]        x_reg;
    logic [CB-1:0]        y_reg;
    logic [CB-1:0]        w_reg;
    logic [CB-1:0]        h_reg;
    logic [TIME_BITS-1:0] last_reg;
    logic [ID_BITS-1:0]   id_reg;
    logic [TIME_BITS-1:0] age;
    logic                 stale;

    // A timestamp that went backwards never makes a track stale.
    assign age   = now - last_reg;
    assign stale = (now > last_reg) && (age > {{(TIME_BITS-14){1'b0}}, max_age});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.write)
        begin
            valid_reg <= 1'b1;
        end
        else if (ctl.shift)
        begin
            valid_reg <= nb_valid;
        end
        else if (ctl.prune && stale)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.write)
        begin
            x_reg    <= wr_x;
            y_reg    <= wr_y;
            w_reg    <= wr_w;
            h_reg    <= wr_h;
            last_reg <= now;
            id_reg   <= wr_id;
        end
        else if (ctl.shift)
        begin
            x_reg    <= nb_x;
            y_reg    <= nb_y;
            w_reg    <= nb_w;
            h_reg    <= nb_h;
            last_reg <= nb_last;
            id_reg   <= nb_id;
        end
    end

    assign valid = valid_reg;
    assign x     = x_reg;
    assign y     = y_reg;
    assign w     = w_reg;
    assign h     = h_reg;
    assign last  = last_reg;
    assign id    = id_reg;

endmodule
`default_nettype wire

### hdl/iouta_eval.sv
// Scoring pipeline, best-match tracker and free-slot finder fed from the head of the slot ring.
`default_nettype none
module iouta_eval
    import iouta_pkg::*;
#(
    parameter int CB  = 13,
    parameter int IXW = 4
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 adv,
    input  wire logic                 mul,
    input  wire logic                 feed,
    input  wire logic                 hv,
    input  wire logic [CB-1:0]        hx,
    input  wire logic [CB-1:0]        hy,
    input  wire logic [CB-1:0]        hw,
    input  wire logic [CB-1:0]        hh,
    input  wire logic [TIME_BITS-1:0] hlast,
    input  wire logic [ID_BITS-1:0]   hid,
    input  wire logic [IXW-1:0]       hidx,
    input  wire logic [CB-1:0]        bx,
    input  wire logic [CB-1:0]        by,
    input  wire logic [CB-1:0]        bw,
    input  wire logic [CB-1:0]        bh,
    input  wire logic [2*CB-1:0]      darea,
    input  wire logic [TIME_BITS-1:0] now,
    input  wire logic [15:0]          min_iou,
    input  wire logic [14:0]          max_ratio,
    output scan_res_t                 res,
    output logic [IXW-1:0]            best_idx,
    output logic [ID_BITS-1:0]        best_id,
    output logic [IXW-1:0]            free_idx
);

    localparam int AW = 2 * CB;
    localparam int UW = AW + 1;
    localparam int PW = AW + UW;
    localparam int RW = AW + 15;

    function automatic logic [CB-1:0] overlap(input logic [CB-1:0] a0, input logic [CB-1:0] al,
                                              input logic [CB-1:0] b0, input logic [CB-1:0] bl);
        logic [CB:0] lo;
        logic [CB:0] ea;
        logic [CB:0] eb;
        logic [CB:0] hi;
        logic [CB:0] d;
        lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
        ea = {1'b0, a0} + {1'b0, al};
        eb = {1'b0, b0} + {1'b0, bl};
        hi = (ea < eb) ? ea : eb;
        d  = hi - lo;
        return (hi > lo) ? d[CB-1:0] : '0;
    endfunction

    logic               v1_reg, v2_reg, v3_reg;
    logic               e1_reg, e2_reg, ok3_reg;
    logic [AW-1:0]      ta1_reg, ta2_reg;
    logic [CB-1:0]      ox1_reg, oy1_reg;
    logic [AW-1:0]      inter2_reg, inter3_reg;
    logic [AW-1:0]      big2_reg, small2_reg;
    logic [UW-1:0]      uni3_reg;
    logic [ID_BITS-1:0] id1_reg, id2_reg, id3_reg;
    logic [IXW-1:0]     ix1_reg, ix2_reg, ix3_reg;
    logic [PW-1:0]      p1_reg, p2_reg;
    logic [AW-1:0]      num_reg;
    logic [UW-1:0]      den_reg;
    logic               found_reg, free_found_reg;
    logic [IXW-1:0]     best_idx_reg, free_idx_reg;
    logic [ID_BITS-1:0] best_id_reg;
    logic [RW-1:0]      ratio_lhs, ratio_rhs;

    assign ratio_lhs = RW'(big2_reg) << 8;
    assign ratio_rhs = RW'(max_ratio) * RW'(small2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (start)
        begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= feed;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (v3_reg && ok3_reg && (p1_reg > p2_reg))
            begin
                found_reg <= 1'b1;
            end
            if (feed && !hv && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= AW'(min_iou);
            den_reg <= UW'(65536);
        end
        else if (mul)
        begin
            p1_reg <= PW'(inter3_reg) * PW'(den_reg);
            p2_reg <= PW'(num_reg) * PW'(uni3_reg);
        end
        else if (adv)
        begin
            e1_reg  <= hv && (hlast != now);
            ta1_reg <= AW'(hw) * AW'(hh);
            ox1_reg <= overlap(hx, hw, bx, bw);
            oy1_reg <= overlap(hy, hh, by, bh);
            id1_reg <= hid;
            ix1_reg <= hidx;

            e2_reg     <= e1_reg;
            ta2_reg    <= ta1_reg;
            inter2_reg <= AW'(ox1_reg) * AW'(oy1_reg);
            big2_reg   <= (ta1_reg > darea) ? ta1_reg : darea;
            small2_reg <= (ta1_reg > darea) ? darea : ta1_reg;
            id2_reg    <= id1_reg;
            ix2_reg    <= ix1_reg;

            ok3_reg    <= e2_reg && (ta2_reg != '0) && (darea != '0) && !(ratio_lhs > ratio_rhs);
            inter3_reg <= inter2_reg;
            uni3_reg   <= UW'(ta2_reg) + UW'(darea) - UW'(inter2_reg);
            id3_reg    <= id2_reg;
            ix3_reg    <= ix2_reg;

            if (v3_reg && ok3_reg && (p1_reg > p2_reg))
            begin
                num_reg      <= inter3_reg;
                den_reg      <= uni3_reg;
                best_idx_reg <= ix3_reg;
                best_id_reg  <= id3_reg;
            end
            if (feed && !hv && !free_found_reg)
            begin
                free_idx_reg <= hidx;
            end
        end
    end

    assign res.found      = found_reg;
    assign res.free_found = free_found_reg;
    assign best_idx       = best_idx_reg;
    assign best_id        = best_id_reg;
    assign free_idx       = free_idx_reg;

endmodule
`default_nettype wire

### hdl/iou_detection_track_associator.sv
// Top level of the greedy IoU associator that maps face boxes onto tracks.
`default_nettype none
// The associator takes one detected box per request and returns one result
// request with a status and a track id. Tracks live in a ring of TRACK_SLOTS
// identical cells; during a lookup the ring rotates one place per compare
// step so that each slot passes the head, where a pipelined scoring unit
// computes areas, the area-ratio gate, the intersection and the union, and
// then compares IoU values exactly by cross-multiplication against the best
// match so far. Because that best-match compare depends on the previous
// slot's outcome, each slot takes a product step and then a compare step,
// which sets the rate. A box rejected as too small or over the per-frame
// count passes through the prune, check and output-wait states to its
// result. A box that goes through the table also passes through the scan
// and decide states. One box is worked on at a time; the next request
// is taken as soon as the result has been moved into the output register,
// even while that result still waits to be taken. Stale tracks are pruned in
// every cell at once on the first box of a frame. Ties in IoU keep the
// lowest slot, and a new track goes into the lowest free slot.
module iou_detection_track_associator
    import iouta_pkg::*;
#(
    parameter int TRACK_SLOTS = 16,
    parameter int COORD_BITS  = 13
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  frame_start,
    input  wire logic [TIME_BITS-1:0]  frame_time_ms,
    input  wire logic [COORD_BITS-1:0] box_x,
    input  wire logic [COORD_BITS-1:0] box_y,
    input  wire logic [COORD_BITS-1:0] box_width,
    input  wire logic [COORD_BITS-1:0] box_height,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [2:0]                 status,
    output logic [ID_BITS-1:0]         track_id,
    input  wire logic                  cfg_we,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [15:0]           cfg_data
);

    localparam int CB  = COORD_BITS;
    localparam int N   = TRACK_SLOTS;
    localparam int IXW = $clog2(N);
    localparam int SCW = $clog2(N + 3);

    // Configuration registers.
    logic [15:0] min_iou_reg;
    logic [14:0] max_ratio_reg;
    logic [13:0] max_age_reg;
    logic [12:0] min_side_reg;
    logic [6:0]  max_boxes_reg;

    // The request being worked on.
    logic                 fs_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [CB-1:0]        bx_reg, by_reg, bw_reg, bh_reg;
    logic [2*CB-1:0]      darea_reg;

    state_t               state_reg, state_next;
    logic                 phase_reg;
    logic [SCW-1:0]       step_reg;
    logic [6:0]           count_reg;
    logic [ID_BITS-1:0]   next_id_reg;
    logic [ID_BITS-1:0]   id_inc;
    status_t              res_status_reg;
    logic [ID_BITS-1:0]   res_id_reg;
    logic                 out_valid_reg;
    status_t              status_reg;
    logic [ID_BITS-1:0]   track_id_reg;

    logic                 accept;
    logic                 too_small;
    logic                 over_count;
    logic                 scanning;
    logic                 adv;
    logic                 mul;
    logic                 feed;
    logic                 scan_done;
    logic                 start;
    logic                 out_load;
    logic                 wr_en;
    logic [IXW-1:0]       wr_idx;
    logic [ID_BITS-1:0]   wr_id;

    scan_res_t            res;
    logic [IXW-1:0]       best_idx;
    logic [ID_BITS-1:0]   best_id;
    logic [IXW-1:0]       free_idx;

    // Ring wiring: cell i loads from cell i+1, the last cell from cell 0.
    cell_ctl_t            ctl [N];
    logic                 c_valid [N];
    logic [CB-1:0]        c_x [N];
    logic [CB-1:0]        c_y [N];
    logic [CB-1:0]        c_w [N];
    logic [CB-1:0]        c_h [N];
    logic [TIME_BITS-1:0] c_last [N];
    logic [ID_BITS-1:0]   c_id [N];

    assign accept     = in_valid && !in_stall;
    assign in_stall   = (state_reg != S_IDLE);
    // Both sides are widened so that any coordinate width up to 32 bits compares exactly.
    assign too_small  = (32'(bw_reg) < 32'(min_side_reg)) ||
                        (32'(bh_reg) < 32'(min_side_reg));
    assign over_count = (count_reg >= max_boxes_reg);
    assign scanning   = (state_reg == S_SCAN);
    assign adv        = scanning && phase_reg;
    assign mul        = scanning && !phase_reg;
    assign feed       = (step_reg < SCW'(N));
    assign scan_done  = adv && (step_reg == SCW'(N + 2));
    assign start      = (state_reg == S_CHECK) && !too_small && !over_count;
    assign out_load   = (state_reg == S_OUTW) && (!out_valid_reg || !out_stall);
    assign id_inc     = next_id_reg + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        wr_en      = 1'b0;
        wr_idx     = best_idx;
        wr_id      = best_id;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_PRUNE;
                end
            end
            S_PRUNE:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = (too_small || over_count) ? S_OUTW : S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_OUTW;
                if (res.found)
                begin
                    wr_en = 1'b1;
                end
                else if (res.free_found)
                begin
                    wr_en  = 1'b1;
                    wr_idx = free_idx;
                    wr_id  = next_id_reg;
                end
            end
            S_OUTW:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= 1'b0;
            step_reg      <= '0;
            count_reg     <= '0;
            next_id_reg   <= ID_BITS'(1);
            out_valid_reg <= 1'b0;
            min_iou_reg   <= 16'd22938;
            max_ratio_reg <= 15'd512;
            max_age_reg   <= 14'd200;
            min_side_reg  <= 13'd20;
            max_boxes_reg <= 7'd10;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MIN_IOU:   min_iou_reg   <= cfg_data;
                    CFG_MAX_RATIO: max_ratio_reg <= cfg_data[14:0];
                    CFG_MAX_AGE:   max_age_reg   <= cfg_data[13:0];
                    CFG_MIN_SIDE:  min_side_reg  <= cfg_data[12:0];
                    CFG_MAX_BOXES: max_boxes_reg <= cfg_data[6:0];
                    default:       ;
                endcase
            end

            if (state_reg == S_PRUNE && fs_reg)
            begin
                count_reg <= '0;
            end
            else if (start)
            begin
                count_reg <= count_reg + 1'b1;
            end

            if (start)
            begin
                phase_reg <= 1'b0;
                step_reg  <= '0;
            end
            else if (scanning)
            begin
                phase_reg <= !phase_reg;
                if (adv)
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end

            // The id counter skips zero when it wraps.
            if (state_reg == S_DECIDE && !res.found && res.free_found)
            begin
                next_id_reg <= (id_inc == '0) ? ID_BITS'(1) : id_inc;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fs_reg  <= frame_start;
            now_reg <= frame_time_ms;
            bx_reg  <= box_x;
            by_reg  <= box_y;
            bw_reg  <= box_width;
            bh_reg  <= box_height;
        end
        if (state_reg == S_PRUNE)
        begin
            darea_reg <= (2*CB)'(bw_reg) * (2*CB)'(bh_reg);
        end
        if (state_reg == S_CHECK)
        begin
            res_id_reg <= '0;
            if (too_small)
            begin
                res_status_reg <= ST_SMALL;
            end
            else
            begin
                res_status_reg <= ST_COUNT;
            end
        end
        if (state_reg == S_DECIDE)
        begin
            if (res.found)
            begin
                res_status_reg <= ST_MATCHED;
                res_id_reg     <= best_id;
            end
            else if (res.free_found)
            begin
                res_status_reg <= ST_NEW;
                res_id_reg     <= next_id_reg;
            end
            else
            begin
                res_status_reg <= ST_FULL;
                res_id_reg     <= '0;
            end
        end
        if (out_load)
        begin
            status_reg   <= res_status_reg;
            track_id_reg <= res_id_reg;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            localparam int NB = (gi + 1) % N;

            assign ctl[gi].shift = adv && feed;
            assign ctl[gi].prune = (state_reg == S_PRUNE) && fs_reg;
            assign ctl[gi].write = wr_en && (wr_idx == IXW'(gi));

            iouta_cell #(
                .CB (CB)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl[gi]),
                .now      (now_reg),
                .max_age  (max_age_reg),
                .nb_valid (c_valid[NB]),
                .nb_x     (c_x[NB]),
                .nb_y     (c_y[NB]),
                .nb_w     (c_w[NB]),
                .nb_h     (c_h[NB]),
                .nb_last  (c_last[NB]),
                .nb_id    (c_id[NB]),
                .wr_x     (bx_reg),
                .wr_y     (by_reg),
                .wr_w     (bw_reg),
                .wr_h     (bh_reg),
                .wr_id    (wr_id),
                .valid    (c_valid[gi]),
                .x        (c_x[gi]),
                .y        (c_y[gi]),
                .w        (c_w[gi]),
                .h        (c_h[gi]),
                .last     (c_last[gi]),
                .id       (c_id[gi])
            );
        end
    endgenerate

    // The head of the ring is cell 0; after step k it holds slot k.
    iouta_eval #(
        .CB  (CB),
        .IXW (IXW)
    ) u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .adv       (adv),
        .mul       (mul),
        .feed      (feed),
        .hv        (c_valid[0]),
        .hx        (c_x[0]),
        .hy        (c_y[0]),
        .hw        (c_w[0]),
        .hh        (c_h[0]),
        .hlast     (c_last[0]),
        .hid       (c_id[0]),
        .hidx      (step_reg[IXW-1:0]),
        .bx        (bx_reg),
        .by        (by_reg),
        .bw        (bw_reg),
        .bh        (bh_reg),
        .darea     (darea_reg),
        .now       (now_reg),
        .min_iou   (min_iou_reg),
        .max_ratio (max_ratio_reg),
        .res       (res),
        .best_idx  (best_idx),
        .best_id   (best_id),
        .free_idx  (free_idx)
    );

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign track_id  = track_id_reg;

endmodule
`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the IoU detection-to-track associator.
`timescale 1ns / 1ps
module testbench;
    import iouta_pkg::*;

    localparam int SLOTS = 16;
    localparam int CB = 13;
    localparam int CYCLE_LIMIT = 1500000;

    // One detection request as it goes into the block.
    typedef struct {
        logic        fstart;
        logic [31:0] ftime;
        logic [12:0] bx;
        logic [12:0] by;
        logic [12:0] bw;
        logic [12:0] bh;
    } det_t;

    // One expected association result.
    typedef struct {
        status_t     st;
        logic [30:0] id;
    } assoc_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic frame_start = 1'b0;
    logic [31:0] frame_time_ms = '0;
    logic [12:0] box_x = '0, box_y = '0, box_width = '0, box_height = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [2:0] status;
    logic [30:0] track_id;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    iou_detection_track_associator #(.TRACK_SLOTS(SLOTS), .COORD_BITS(CB)) u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .frame_start(frame_start), .frame_time_ms(frame_time_ms),
        .box_x(box_x), .box_y(box_y), .box_width(box_width), .box_height(box_height),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .track_id(track_id),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Shadow of the configuration registers and the track table.
    logic [15:0] thr_iou;
    logic [14:0] max_ratio;
    logic [13:0] max_age;
    logic [12:0] min_side;
    logic [6:0]  max_boxes;
    logic        trk_live [SLOTS];
    logic [12:0] trk_x [SLOTS], trk_y [SLOTS], trk_w [SLOTS], trk_h [SLOTS];
    logic [31:0] trk_seen [SLOTS];
    logic [30:0] trk_id [SLOTS];
    logic [30:0] id_next;
    logic [6:0]  boxes_in_frame;

    det_t   pending_dets[$];
    assoc_t expected_assoc[$];
    int     errors = 0;
    int     cycles = 0;
    bit     hold_receiver = 1'b0;
    bit     sender_pause = 1'b0;

    // Acceptance is decided at the rising edge; the driver consumes it after.
    logic in_stall_q = 1'b1;
    int gap_left = 0;

    function automatic logic [12:0] overlap(logic [12:0] a0, logic [12:0] al,
                                            logic [12:0] b0, logic [12:0] bl);
        logic [13:0] lo, hi, ea, eb;
        lo = (a0 > b0) ? a0 : b0;
        ea = a0 + al;
        eb = b0 + bl;
        hi = (ea < eb) ? ea : eb;
        return (hi > lo) ? 13'(hi - lo) : 13'd0;
    endfunction

    // Works out the association for one box and updates the shadow table.
    function automatic assoc_t associate(det_t d);
        assoc_t r;
        logic [25:0] darea, tarea, big, lit, inter;
        logic [26:0] uni, best_den;
        logic [25:0] best_num;
        int best;
        if (d.fstart)
        begin
            for (int i = 0; i < SLOTS; i++)
                if (trk_live[i] && d.ftime > trk_seen[i] &&
                    (d.ftime - trk_seen[i]) > {18'd0, max_age})
                    trk_live[i] = 1'b0;
            boxes_in_frame = '0;
        end
        r.id = '0;
        if (d.bw < min_side || d.bh < min_side)
        begin
            r.st = ST_SMALL;
            return r;
        end
        if (boxes_in_frame >= max_boxes)
        begin
            r.st = ST_COUNT;
            return r;
        end
        boxes_in_frame++;
        darea = d.bw * d.bh;
        best_num = thr_iou;
        best_den = 27'd65536;
        best = -1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!trk_live[i] || trk_seen[i] == d.ftime)
                continue;
            tarea = trk_w[i] * trk_h[i];
            if (tarea == 0 || darea == 0)
                continue;
            big = (tarea > darea) ? tarea : darea;
            lit = (tarea > darea) ? darea : tarea;
            if (64'(big) * 256 > 64'(max_ratio) * 64'(lit))
                continue;
            inter = overlap(trk_x[i], trk_w[i], d.bx, d.bw) *
                    overlap(trk_y[i], trk_h[i], d.by, d.bh);
            uni = tarea + darea - inter;
            if (64'(inter) * 64'(best_den) > 64'(best_num) * 64'(uni))
            begin
                best_num = inter;
                best_den = uni;
                best = i;
            end
        end
        r.st = ST_MATCHED;
        if (best < 0)
        begin
            for (int i = 0; i < SLOTS; i++)
                if (!trk_live[i])
                begin
                    best = i;
                    break;
                end
            if (best < 0)
            begin
                r.st = ST_FULL;
                return r;
            end
            trk_id[best] = id_next;
            id_next = id_next + 1;
            if (id_next == 0)
                id_next = 1;
            r.st = ST_NEW;
        end
        trk_live[best] = 1'b1;
        trk_x[best] = d.bx;
        trk_y[best] = d.by;
        trk_w[best] = d.bw;
        trk_h[best] = d.bh;
        trk_seen[best] = d.ftime;
        r.id = trk_id[best];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Appends one box to the tail of the stimulus queue.
    task automatic queue_det(det_t d);
        pending_dets.insert(pending_dets.size(), d);
    endtask

    // Register writes happen only while the block is idle, at the falling edge.
    task automatic write_reg(cfg_index_t idx, logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MIN_IOU:   thr_iou = val;
            CFG_MAX_RATIO: max_ratio = val[14:0];
            CFG_MAX_AGE:   max_age = val[13:0];
            CFG_MIN_SIDE:  min_side = val[12:0];
            CFG_MAX_BOXES: max_boxes = val[6:0];
            default: ;
        endcase
    endtask

    // Lets the queue drain, then a little more for rejected boxes in flight.
    task automatic settle();
        while (pending_dets.size() != 0 || expected_assoc.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    function automatic det_t make_det(logic fs, logic [31:0] t, int x, int y, int w, int h);
        det_t d;
        d.fstart = fs;
        d.ftime = t;
        d.bx = 13'(x);
        d.by = 13'(y);
        d.bw = 13'(w);
        d.bh = 13'(h);
        return d;
    endfunction

    // Pushes one random frame of boxes, most jittered around a set of faces.
    logic [31:0] clock_ms = 32'd1000;
    logic [12:0] face_x [6], face_y [6], face_s [6];

    task automatic push_frame(int nboxes);
        int k;
        det_t d;
        clock_ms = clock_ms + $urandom_range(1, ($urandom_range(0, 9) == 0) ? 600 : 60);
        if ($urandom_range(0, 30) == 0)
            clock_ms = clock_ms - $urandom_range(1, 500);
        for (int b = 0; b < nboxes; b++)
        begin
            case ($urandom_range(0, 9))
                0: d = make_det(0, $urandom, $urandom, $urandom, $urandom, $urandom);
                1: d = make_det(0, clock_ms, $urandom_range(0, 8191), $urandom_range(0, 8191),
                                $urandom_range(0, 30), $urandom_range(0, 30));
                default:
                begin
                    k = $urandom_range(0, 5);
                    if ($urandom_range(0, 19) == 0)
                    begin
                        face_s[k] = $urandom_range(16, 400);
                        face_x[k] = $urandom_range(0, 7000);
                        face_y[k] = $urandom_range(0, 7000);
                    end
                    face_x[k] = face_x[k] + $urandom_range(0, 8) - 4;
                    face_y[k] = face_y[k] + $urandom_range(0, 8) - 4;
                    d = make_det(0, clock_ms, face_x[k], face_y[k],
                                 face_s[k] + $urandom_range(0, 10),
                                 face_s[k] + $urandom_range(0, 10));
                end
            endcase
            d.fstart = (b == 0);
            if (b != 0 && $urandom_range(0, 40) == 0)
                d.ftime = clock_ms + 1;
            queue_det(d);
        end
    endtask

    // Driver: offers the head of the queue, changes inputs at the falling edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall_q)
            begin
                expected_assoc.insert(expected_assoc.size(),
                                      associate(pending_dets.pop_front()));
            end
            if ((!in_valid || !in_stall_q) )
            begin
                if (pending_dets.size() != 0 && !sender_pause &&
                    (in_valid ? $urandom_range(0, 3) != 0 : gap_left == 0))
                begin
                    in_valid <= 1'b1;
                    frame_start <= pending_dets[0].fstart;
                    frame_time_ms <= pending_dets[0].ftime;
                    box_x <= pending_dets[0].bx;
                    box_y <= pending_dets[0].by;
                    box_width <= pending_dets[0].bw;
                    box_height <= pending_dets[0].bh;
                    gap_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 80)
                                                             : $urandom_range(0, 3);
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (gap_left != 0)
                        gap_left <= gap_left - 1;
                end
            end
        end
    end

    always @(posedge clk)
        in_stall_q <= in_stall;

    // Monitor: checks results at the rising edge, stalls change at the falling edge.
    int hold_count = 0;
    always @(posedge clk)
    begin
        assoc_t want;
        cycles <= cycles + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_assoc.size() == 0)
            begin
                report_mismatch("unexpected result status", status, -1);
            end
            else
            begin
                want = expected_assoc.pop_front();
                if (status !== want.st)
                    report_mismatch("status", status, want.st);
                if (track_id !== want.id)
                    report_mismatch("track_id", track_id, want.id);
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_receiver)
        begin
            out_stall <= 1'b1;
        end
        else if (hold_count != 0)
        begin
            hold_count <= hold_count - 1;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            out_stall <= 1'b1;
            hold_count <= ($urandom_range(0, 20) == 0) ? $urandom_range(10, 100)
                                                      : $urandom_range(0, 2);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        thr_iou = 16'd22938;
        max_ratio = 15'd512;
        max_age = 14'd200;
        min_side = 13'd20;
        max_boxes = 7'd10;
        for (int i = 0; i < SLOTS; i++)
            trk_live[i] = 1'b0;
        id_next = 31'd1;
        boxes_in_frame = '0;
        for (int k = 0; k < 6; k++)
        begin
            face_x[k] = $urandom_range(0, 7000);
            face_y[k] = $urandom_range(0, 7000);
            face_s[k] = $urandom_range(20, 300);
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, the new, matched and too-small statuses, pruning and backwards time.
        queue_det(make_det(1, 32'd100, 0, 0, 8191, 8191));
        queue_det(make_det(0, 32'd100, 8191, 8191, 19, 40));
        queue_det(make_det(0, 32'd100, 0, 0, 40, 0));
        queue_det(make_det(1, 32'd101, 0, 0, 8191, 8191));
        queue_det(make_det(1, 32'd150, 100, 100, 50, 50));
        queue_det(make_det(1, 32'd200, 102, 101, 50, 52));
        queue_det(make_det(0, 32'd200, 104, 100, 50, 50));
        queue_det(make_det(1, 32'd50, 100, 100, 50, 50));
        queue_det(make_det(1, 32'hFFFF_FFFF, 5000, 5000, 8191, 8191));
        queue_det(make_det(0, 32'hFFFF_FFFF, 4096, 2730, 5461, 1365));
        settle();

        // Fill the table to see the full flag; loose count limit first.
        write_reg(CFG_MAX_BOXES, 16'd64);
        for (int i = 0; i < 18; i++)
            queue_det(make_det(i == 0, 32'hFFFF_FFFF, i * 300, 0, 40, 40));
        settle();

        // Sender stall: block fills and holds its input while the receiver waits.
        hold_receiver = 1'b1;
        push_frame(12);
        repeat (400) @(negedge clk);
        hold_receiver = 1'b0;
        settle();

        // Random phases across several register settings, extremes included.
        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph)
                0: begin
                    write_reg(CFG_MIN_IOU, 16'd0);
                    write_reg(CFG_MAX_RATIO, 16'd25600);
                    write_reg(CFG_MAX_AGE, 16'd0);
                    write_reg(CFG_MIN_SIDE, 16'd8);
                    write_reg(CFG_MAX_BOXES, 16'd1);
                end
                1: begin
                    write_reg(CFG_MIN_IOU, 16'd65535);
                    write_reg(CFG_MAX_RATIO, 16'd256);
                    write_reg(CFG_MAX_AGE, 16'd10000);
                    write_reg(CFG_MIN_SIDE, 16'd8191);
                    write_reg(CFG_MAX_BOXES, 16'd64);
                end
                2: begin
                    write_reg(CFG_MIN_SIDE, 16'd0);
                    write_reg(CFG_MAX_BOXES, 16'd0);
                end
                3: begin
                    write_reg(CFG_MIN_IOU, 16'hFFFF);
                    write_reg(CFG_MAX_RATIO, 16'h7FFF);
                    write_reg(CFG_MAX_AGE, 16'h3FFF);
                    write_reg(CFG_MIN_SIDE, 16'h1FFF);
                    write_reg(CFG_MAX_BOXES, 16'h7F);
                end
                default: begin
                    write_reg(CFG_MIN_IOU, 16'($urandom_range(0, 65535)));
                    write_reg(CFG_MAX_RATIO, 16'($urandom_range(256, 2000)));
                    write_reg(CFG_MAX_AGE, 16'($urandom_range(0, 400)));
                    write_reg(CFG_MIN_SIDE, 16'($urandom_range(0, 30)));
                    write_reg(CFG_MAX_BOXES, 16'($urandom_range(1, 20)));
                end
            endcase
            for (int f = 0; f < 19; f++)
                push_frame($urandom_range(1, 14));
            if (ph == 4)
            begin
                // Sender waits here until every expected result is back.
                while (pending_dets.size() != 0)
                    @(negedge clk);
                sender_pause = 1'b1;
                while (expected_assoc.size() != 0)
                    @(negedge clk);
                sender_pause = 1'b0;
            end
            settle();
        end

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
